FILE: sv/tcc_pkg.sv
// Shared widths, payload types and queue entry type for the circumcenter unit.
package tcc_pkg;

  localparam int CoordWidth = 16;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int ProdWidth  = 2 * CoordWidth + 1;
  localparam int SqWidth    = 2 * CoordWidth + 1;
  localparam int DetWidth   = 2 * CoordWidth + 4;
  localparam int TermWidth  = 3 * CoordWidth + 3;
  localparam int NumWidth   = 3 * CoordWidth + 5;
  localparam int RemWidth   = DetWidth;
  localparam int QueueDepth = 2;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by_coord;
    coord_t cx;
    coord_t cy;
  } in_item_t;

  typedef struct packed {
    coord_t center_x;
    coord_t center_y;
    logic   degenerate;
    logic   saturated;
  } out_item_t;

  // Work handed from the front to the back: magnitudes of the two numerators
  // and of the determinant, the quotient signs and the degenerate flag.
  typedef struct packed {
    logic [NumWidth-1:0] nx_mag;
    logic [NumWidth-1:0] ny_mag;
    logic                x_neg;
    logic                y_neg;
    logic [DetWidth-1:0] det_mag;
    logic                degenerate;
  } job_t;

endpackage

FILE: sv/tcc_front.sv
// Front pipeline: differences, products, numerators and determinant.
module tcc_front import tcc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     job_valid_o,
  input  logic     job_ready_i,
  output job_t     job_o
);

  typedef struct packed {
    coord_t ax, ay, bx, by_coord, cx, cy;
    logic signed [DiffWidth-1:0] d_bc_y, d_ca_y, d_ab_y, d_cb_x, d_ac_x, d_ba_x;
  } s1_t;

  typedef struct packed {
    logic signed [ProdWidth-1:0] pa, pb, pc;
    logic [SqWidth-1:0] sa, sb, sc;
    logic signed [DiffWidth-1:0] d_bc_y, d_ca_y, d_ab_y, d_cb_x, d_ac_x, d_ba_x;
  } s2_t;

  typedef struct packed {
    logic signed [TermWidth-1:0] xa, xb, xc, ya, yb, yc;
    logic signed [DetWidth-1:0]  det;
  } s3_t;

  typedef struct packed {
    logic signed [NumWidth-1:0] nx, ny;
    logic signed [DetWidth-1:0] det;
  } s4_t;

  localparam int Stages = 5;

  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  s4_t  s4_d, s4_q;
  job_t s5_d, s5_q;
  logic [Stages-1:0] valid_q;
  logic advance;

  logic signed [SqWidth:0] sqa, sqb, sqc;
  logic signed [DetWidth-1:0] det_sum;

  assign advance     = !valid_q[Stages-1] || job_ready_i;
  assign in_ready_o  = advance;
  assign job_valid_o = valid_q[Stages-1];
  assign job_o       = s5_q;

  always_comb begin
    s1_d.ax       = in_data_i.ax;
    s1_d.ay       = in_data_i.ay;
    s1_d.bx       = in_data_i.bx;
    s1_d.by_coord = in_data_i.by_coord;
    s1_d.cx       = in_data_i.cx;
    s1_d.cy       = in_data_i.cy;
    s1_d.d_bc_y = DiffWidth'(in_data_i.by_coord) - DiffWidth'(in_data_i.cy);
    s1_d.d_ca_y = DiffWidth'(in_data_i.cy) - DiffWidth'(in_data_i.ay);
    s1_d.d_ab_y = DiffWidth'(in_data_i.ay) - DiffWidth'(in_data_i.by_coord);
    s1_d.d_cb_x = DiffWidth'(in_data_i.cx) - DiffWidth'(in_data_i.bx);
    s1_d.d_ac_x = DiffWidth'(in_data_i.ax) - DiffWidth'(in_data_i.cx);
    s1_d.d_ba_x = DiffWidth'(in_data_i.bx) - DiffWidth'(in_data_i.ax);
  end

  always_comb begin
    s2_d.pa = ProdWidth'(s1_q.ax) * ProdWidth'(s1_q.d_bc_y);
    s2_d.pb = ProdWidth'(s1_q.bx) * ProdWidth'(s1_q.d_ca_y);
    s2_d.pc = ProdWidth'(s1_q.cx) * ProdWidth'(s1_q.d_ab_y);
    sqa = (SqWidth+1)'(s1_q.ax) * (SqWidth+1)'(s1_q.ax)
        + (SqWidth+1)'(s1_q.ay) * (SqWidth+1)'(s1_q.ay);
    sqb = (SqWidth+1)'(s1_q.bx) * (SqWidth+1)'(s1_q.bx)
        + (SqWidth+1)'(s1_q.by_coord) * (SqWidth+1)'(s1_q.by_coord);
    sqc = (SqWidth+1)'(s1_q.cx) * (SqWidth+1)'(s1_q.cx)
        + (SqWidth+1)'(s1_q.cy) * (SqWidth+1)'(s1_q.cy);
    s2_d.sa = sqa[SqWidth-1:0];
    s2_d.sb = sqb[SqWidth-1:0];
    s2_d.sc = sqc[SqWidth-1:0];
    s2_d.d_bc_y = s1_q.d_bc_y;
    s2_d.d_ca_y = s1_q.d_ca_y;
    s2_d.d_ab_y = s1_q.d_ab_y;
    s2_d.d_cb_x = s1_q.d_cb_x;
    s2_d.d_ac_x = s1_q.d_ac_x;
    s2_d.d_ba_x = s1_q.d_ba_x;
  end

  always_comb begin
    det_sum = DetWidth'(s2_q.pa) + DetWidth'(s2_q.pb) + DetWidth'(s2_q.pc);
    s3_d.det = {det_sum[DetWidth-2:0], 1'b0};
    s3_d.xa = TermWidth'($signed({1'b0, s2_q.sa})) * TermWidth'(s2_q.d_bc_y);
    s3_d.xb = TermWidth'($signed({1'b0, s2_q.sb})) * TermWidth'(s2_q.d_ca_y);
    s3_d.xc = TermWidth'($signed({1'b0, s2_q.sc})) * TermWidth'(s2_q.d_ab_y);
    s3_d.ya = TermWidth'($signed({1'b0, s2_q.sa})) * TermWidth'(s2_q.d_cb_x);
    s3_d.yb = TermWidth'($signed({1'b0, s2_q.sb})) * TermWidth'(s2_q.d_ac_x);
    s3_d.yc = TermWidth'($signed({1'b0, s2_q.sc})) * TermWidth'(s2_q.d_ba_x);
  end

  always_comb begin
    s4_d.nx  = NumWidth'(s3_q.xa) + NumWidth'(s3_q.xb) + NumWidth'(s3_q.xc);
    s4_d.ny  = NumWidth'(s3_q.ya) + NumWidth'(s3_q.yb) + NumWidth'(s3_q.yc);
    s4_d.det = s3_q.det;
  end

  // Sign and magnitude form for the restoring divider.
  always_comb begin
    s5_d.nx_mag     = s4_q.nx[NumWidth-1] ? -s4_q.nx : s4_q.nx;
    s5_d.ny_mag     = s4_q.ny[NumWidth-1] ? -s4_q.ny : s4_q.ny;
    s5_d.det_mag    = s4_q.det[DetWidth-1] ? -s4_q.det : s4_q.det;
    s5_d.x_neg      = s4_q.nx[NumWidth-1] ^ s4_q.det[DetWidth-1];
    s5_d.y_neg      = s4_q.ny[NumWidth-1] ^ s4_q.det[DetWidth-1];
    s5_d.degenerate = (s4_q.det == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[Stages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
    end
  end

endmodule

FILE: sv/tcc_fifo.sv
// Small register queue that decouples the front and back pipelines.
module tcc_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountWidth = $clog2(Depth + 1);

  logic [Width-1:0]      mem_q [Depth];
  logic [PtrWidth-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CountWidth-1:0] count_q;
  logic push, pop;

  assign push_ready_o = (count_q != CountWidth'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: sv/tcc_back.sv
// Back pipeline: two pipelined restoring dividers, clamping and output register.
module tcc_back import tcc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  job_t      job_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  typedef struct packed {
    logic [RemWidth-1:0]   rem;
    logic [CoordWidth-1:0] low;
    logic [CoordWidth-1:0] quo;
    logic                  ovf;
    logic                  neg;
  } lane_t;

  typedef struct packed {
    lane_t               x;
    lane_t               y;
    logic [DetWidth-1:0] dm;
    logic                deg;
  } stage_t;

  typedef struct packed {
    coord_t value;
    logic   sat;
  } clamp_t;

  localparam int HiWidth = NumWidth - CoordWidth;

  // The high part of the magnitude seeds the remainder; if it already
  // reaches the divisor the quotient has more than CoordWidth bits.
  function automatic lane_t seed(logic [NumWidth-1:0] mag, logic neg,
                                 logic [DetWidth-1:0] dm);
    lane_t l;
    logic [HiWidth-1:0] hi;
    hi    = mag[NumWidth-1:CoordWidth];
    l.ovf = (HiWidth'(dm) <= hi);
    l.rem = l.ovf ? '0 : hi[RemWidth-1:0];
    l.low = mag[CoordWidth-1:0];
    l.quo = '0;
    l.neg = neg;
    return l;
  endfunction

  function automatic lane_t div_step(lane_t l, logic [DetWidth-1:0] dm);
    lane_t r;
    logic [RemWidth:0] t;
    r = l;
    t = {l.rem, l.low[CoordWidth-1]};
    if (t >= {1'b0, dm}) begin
      r.rem = RemWidth'(t - {1'b0, dm});
      r.quo = {l.quo[CoordWidth-2:0], 1'b1};
    end else begin
      r.rem = t[RemWidth-1:0];
      r.quo = {l.quo[CoordWidth-2:0], 1'b0};
    end
    r.low = {l.low[CoordWidth-2:0], 1'b0};
    return r;
  endfunction

  function automatic clamp_t clamp(lane_t l);
    clamp_t c;
    logic [CoordWidth-1:0] lim;
    logic [CoordWidth-1:0] val;
    lim   = l.neg ? {1'b1, {(CoordWidth-1){1'b0}}} : {1'b0, {(CoordWidth-1){1'b1}}};
    c.sat = l.ovf || (l.quo > lim);
    val   = c.sat ? lim : l.quo;
    c.value = l.neg ? -val : val;
    return c;
  endfunction

  stage_t               stage_q [CoordWidth+1];
  logic [CoordWidth:0]  valid_q;
  logic                 out_valid_q;
  out_item_t            out_d, out_q;
  logic                 advance;
  clamp_t               cx, cy;

  assign advance     = !out_valid_q || out_ready_i;
  assign job_ready_o = advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      valid_q     <= {valid_q[CoordWidth-1:0], job_valid_i};
      out_valid_q <= valid_q[CoordWidth];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      stage_q[0].x   <= seed(job_i.nx_mag, job_i.x_neg, job_i.det_mag);
      stage_q[0].y   <= seed(job_i.ny_mag, job_i.y_neg, job_i.det_mag);
      stage_q[0].dm  <= job_i.det_mag;
      stage_q[0].deg <= job_i.degenerate;
    end
  end

  for (genvar k = 1; k <= CoordWidth; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (advance) begin
        stage_q[k].x   <= div_step(stage_q[k-1].x, stage_q[k-1].dm);
        stage_q[k].y   <= div_step(stage_q[k-1].y, stage_q[k-1].dm);
        stage_q[k].dm  <= stage_q[k-1].dm;
        stage_q[k].deg <= stage_q[k-1].deg;
      end
    end
  end

  always_comb begin
    cx = clamp(stage_q[CoordWidth].x);
    cy = clamp(stage_q[CoordWidth].y);
    if (stage_q[CoordWidth].deg) begin
      out_d.center_x   = '0;
      out_d.center_y   = '0;
      out_d.degenerate = 1'b1;
      out_d.saturated  = 1'b0;
    end else begin
      out_d.center_x   = cx.value;
      out_d.center_y   = cy.value;
      out_d.degenerate = 1'b0;
      out_d.saturated  = cx.sat || cy.sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

endmodule

FILE: sv/triangle_circumcenter_unit.sv
// Throughput: one triangle per cycle while the output side accepts results; the front and
// back pipelines each advance every cycle their downstream side can take data, and a
// QueueDepth-entry queue sits between.
// The division is a restoring divider unrolled into one pipeline stage per quotient bit.
// Reset clears only valid bits, queue pointers and the queue count; data registers are not reset.
module triangle_circumcenter_unit import tcc_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  // The front computes coordinate differences, squared radii, the
  // determinant and both numerators exactly, then hands sign and magnitude
  // to the queue. Each pipeline stalls as a whole only when its last stage
  // holds data that cannot move on.
  logic job_in_valid, job_in_ready;
  job_t job_in;
  logic job_out_valid, job_out_ready;
  logic [$bits(job_t)-1:0] job_out_bits;

  tcc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_in_valid),
    .job_ready_i (job_in_ready),
    .job_o       (job_in)
  );

  // A short queue lets the front keep accepting transfers while the back is
  // held by the output side, and the reverse.
  tcc_fifo #(
    .Width ($bits(job_t)),
    .Depth (QDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_in_valid),
    .push_ready_o (job_in_ready),
    .push_data_i  (job_in),
    .pop_valid_o  (job_out_valid),
    .pop_ready_i  (job_out_ready),
    .pop_data_o   (job_out_bits)
  );

  // The back divides both numerators by the determinant, truncating toward
  // zero, and clamps to the coordinate range. Collinear vertices give zeros
  // with the degenerate flag.
  tcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_out_valid),
    .job_ready_o (job_out_ready),
    .job_i       (job_t'(job_out_bits)),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
